// ----- rtl/rational_arith_reduce_defines.svh -----
// assertion macros for the rational arithmetic block
// no dependencies; included by modules that carry checks
`ifndef RATIONAL_ARITH_REDUCE_DEFINES_SVH
`define RATIONAL_ARITH_REDUCE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RAR_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("rar check failed");
`define RAR_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rar check failed");
`define RAR_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rar check failed");
`else
`define RAR_ASSERT(lbl, expr)
`define RAR_IMPLY(lbl, ante, cons)
`define RAR_NEXT(lbl, ante, cons)
`endif
`endif

// ----- rtl/rar_pkg.sv -----
// shared types and constants for the rational arithmetic block
// no dependencies
package rar_pkg;

    localparam int RAR_OPERAND_WIDTH = 32;
    localparam int RAR_MUL_IN_W      = 33;
    localparam int RAR_WORD_W        = 64;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_DIV = 3'd3,
        MODE_CMP = 3'd4
    } rar_mode_t;

    localparam logic [1:0] ORD_LESS    = 2'd0;
    localparam logic [1:0] ORD_EQUAL   = 2'd1;
    localparam logic [1:0] ORD_GREATER = 2'd2;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_DIVZERO = 1'b1;

endpackage

// ----- rtl/rational_arith_reduce.sv -----
// rational arithmetic with lowest-terms reduction, top level
// depends on rar_pkg and rational_arith_reduce_defines.svh
`include "rational_arith_reduce_defines.svh"

// Takes one item of two fractions and a mode (add, subtract, multiply,
// divide, compare) and returns one result item reduced to lowest terms,
// sign on the numerator. One item at a time: in_ready is high only while
// the sequencer is idle. An item goes through the multiply steps S_MUL0,
// S_MUL1 and S_MUL2 (one shared 33x33 multiplier), the setup step S_PREP,
// a binary gcd loop of one 64-bit compare/subtract or shift per cycle,
// then restoring division of numerator and denominator by the gcd on
// one shared subtractor, and the step S_FIN that hands the result to the
// output register once it is free or being taken. Zero results and
// compare mode skip the gcd and division; error cases and unknown modes
// go from idle straight to S_FIN. The output register holds a finished
// item until taken, so the next item can already be accepted and worked on.
module rational_arith_reduce
    import rar_pkg::*;
#(
    parameter int OPERAND_WIDTH = RAR_OPERAND_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         mode,
    input  logic signed [31:0] a_num,
    input  logic [30:0]        a_den,
    input  logic signed [31:0] b_num,
    input  logic [30:0]        b_den,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [63:0] res_num,
    output logic [62:0]        res_den,
    output logic [1:0]         order,
    output logic               status
);

    localparam int DIV_STEPS = RAR_WORD_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_MUL0 = 9'b000000010,
        S_MUL1 = 9'b000000100,
        S_MUL2 = 9'b000001000,
        S_PREP = 9'b000010000,
        S_GCD  = 9'b000100000,
        S_DIVN = 9'b001000000,
        S_DIVD = 9'b010000000,
        S_FIN  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // operands, sign- or zero-extended to the multiplier width
    logic signed [RAR_MUL_IN_W-1:0] an_x, ad_x, bn_x, bd_x;
    logic signed [RAR_MUL_IN_W-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [RAR_MUL_IN_W-1:0] an_next, ad_next, bn_next, bd_next;
    logic [2:0] mode_reg, mode_next;

    // products
    logic signed [RAR_WORD_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [RAR_WORD_W-1:0] p0_next, p1_next, p2_next;

    // gcd and divider working registers
    logic [RAR_WORD_W-1:0] gx_reg, gy_reg, md_reg, dv_reg, quo_reg;
    logic [RAR_WORD_W-1:0] gx_next, gy_next, md_next, dv_next, quo_next;
    logic [RAR_WORD_W:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]      gk_reg, gk_next, cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;

    // pending result
    logic signed [RAR_WORD_W-1:0] rn_reg, rn_next;
    logic [62:0]                  rd_reg, rd_next;
    logic [1:0]                   ro_reg, ro_next;
    logic                         rs_reg, rs_next;

    // output register
    logic                         ov_reg, ov_next;
    logic signed [RAR_WORD_W-1:0] on_reg, on_next;
    logic [62:0]                  od_reg, od_next;
    logic [1:0]                   oo_reg, oo_next;
    logic                         os_reg, os_next;

    // shared multiplier
    logic signed [RAR_MUL_IN_W-1:0]   mul_a, mul_b;
    logic signed [2*RAR_MUL_IN_W-1:0] prod;
    logic signed [RAR_WORD_W-1:0]     prod_w;

    // setup terms
    logic signed [RAR_WORD_W-1:0] n_val, d_val;
    logic [RAR_WORD_W-1:0]        mn_val, md_val;

    // shared subtractor
    logic [RAR_WORD_W:0] sub_a, sub_b, diff;
    logic [RAR_WORD_W:0] rem_sh;

    logic in_fire;

    // only the low OPERAND_WIDTH bits of each numerator and OPERAND_WIDTH-1 bits of each denominator are used
    assign an_x = $signed({{(RAR_MUL_IN_W-OPERAND_WIDTH){a_num[OPERAND_WIDTH-1]}},
                           a_num[OPERAND_WIDTH-1:0]});
    assign bn_x = $signed({{(RAR_MUL_IN_W-OPERAND_WIDTH){b_num[OPERAND_WIDTH-1]}},
                           b_num[OPERAND_WIDTH-1:0]});
    assign ad_x = $signed({{(RAR_MUL_IN_W-OPERAND_WIDTH+1){1'b0}},
                           a_den[OPERAND_WIDTH-2:0]});
    assign bd_x = $signed({{(RAR_MUL_IN_W-OPERAND_WIDTH+1){1'b0}},
                           b_den[OPERAND_WIDTH-2:0]});

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    // multiplier operand select per step
    always_comb
    begin
        mul_a = an_reg;
        mul_b = bd_reg;
        case (state_reg)
            S_MUL0:
            begin
                mul_a = an_reg;
                mul_b = (mode_reg == MODE_MUL) ? bn_reg : bd_reg;
            end
            S_MUL1:
            begin
                mul_a = ad_reg;
                mul_b = (mode_reg == MODE_MUL) ? bd_reg : bn_reg;
            end
            S_MUL2:
            begin
                mul_a = ad_reg;
                mul_b = bd_reg;
            end
            default:
            begin
                mul_a = an_reg;
                mul_b = bd_reg;
            end
        endcase
    end

    assign prod   = mul_a * mul_b;
    assign prod_w = prod[RAR_WORD_W-1:0];

    // fraction before reduction
    always_comb
    begin
        case (mode_reg)
            MODE_ADD:
            begin
                n_val = p0_reg + p1_reg;
                d_val = p2_reg;
            end
            MODE_SUB:
            begin
                n_val = p0_reg - p1_reg;
                d_val = p2_reg;
            end
            default:
            begin
                n_val = p0_reg;
                d_val = p1_reg;
            end
        endcase
    end

    assign mn_val = n_val[RAR_WORD_W-1] ? RAR_WORD_W'(-n_val) : RAR_WORD_W'(n_val);
    assign md_val = d_val[RAR_WORD_W-1] ? RAR_WORD_W'(-d_val) : RAR_WORD_W'(d_val);

    // one subtractor serves gcd compare and division step
    assign rem_sh = {rem_reg[RAR_WORD_W-1:0], quo_reg[RAR_WORD_W-1]};
    always_comb
    begin
        if (state_reg == S_GCD)
        begin
            sub_a = {1'b0, gx_reg};
            sub_b = {1'b0, gy_reg};
        end
        else
        begin
            sub_a = rem_sh;
            sub_b = {1'b0, dv_reg};
        end
    end
    assign diff = sub_a - sub_b;

    always_comb
    begin
        state_next = state_reg;
        an_next = an_reg;  ad_next = ad_reg;  bn_next = bn_reg;  bd_next = bd_reg;
        mode_next = mode_reg;
        p0_next = p0_reg;  p1_next = p1_reg;  p2_next = p2_reg;
        gx_next = gx_reg;  gy_next = gy_reg;  gk_next = gk_reg;
        md_next = md_reg;  dv_next = dv_reg;  quo_next = quo_reg;
        rem_next = rem_reg;  cnt_next = cnt_reg;  neg_next = neg_reg;
        rn_next = rn_reg;  rd_next = rd_reg;  ro_next = ro_reg;  rs_next = rs_reg;
        ov_next = ov_reg;  on_next = on_reg;  od_next = od_reg;
        oo_next = oo_reg;  os_next = os_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    an_next   = an_x;
                    ad_next   = ad_x;
                    bn_next   = bn_x;
                    bd_next   = bd_x;
                    mode_next = mode;
                    rn_next   = '0;
                    rd_next   = 63'd1;
                    ro_next   = ORD_LESS;
                    rs_next   = ST_OK;
                    if (!(mode inside {MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_CMP}))
                    begin
                        state_next = S_FIN;
                    end
                    else if (ad_x == '0 || bd_x == '0 ||
                             (mode == MODE_DIV && bn_x == '0))
                    begin
                        // zero denominator or division by a zero fraction
                        rs_next    = ST_DIVZERO;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_MUL0;
                    end
                end
            end
            S_MUL0:
            begin
                p0_next    = prod_w;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                p1_next    = prod_w;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                p2_next    = prod_w;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                if (mode_reg == MODE_CMP)
                begin
                    if (p0_reg < p1_reg)
                        ro_next = ORD_LESS;
                    else if (p0_reg == p1_reg)
                        ro_next = ORD_EQUAL;
                    else
                        ro_next = ORD_GREATER;
                    state_next = S_FIN;
                end
                else if (mn_val == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    neg_next   = n_val[RAR_WORD_W-1] ^ d_val[RAR_WORD_W-1];
                    gx_next    = mn_val;
                    gy_next    = md_val;
                    gk_next    = '0;
                    quo_next   = mn_val;
                    md_next    = md_val;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (gx_reg == '0)
                begin
                    dv_next    = gy_reg << gk_reg;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_DIVN;
                end
                else if (!gx_reg[0] && !gy_reg[0])
                begin
                    gx_next = gx_reg >> 1;
                    gy_next = gy_reg >> 1;
                    gk_next = gk_reg + 1'b1;
                end
                else if (!gx_reg[0])
                begin
                    gx_next = gx_reg >> 1;
                end
                else if (!gy_reg[0])
                begin
                    gy_next = gy_reg >> 1;
                end
                else if (!diff[RAR_WORD_W])
                begin
                    gx_next = diff[RAR_WORD_W-1:0];
                end
                else
                begin
                    gy_next = RAR_WORD_W'(gy_reg - gx_reg);
                end
            end
            S_DIVN, S_DIVD:
            begin
                // restoring division, one quotient bit per cycle
                quo_next = {quo_reg[RAR_WORD_W-2:0], !diff[RAR_WORD_W]};
                rem_next = diff[RAR_WORD_W] ? rem_sh : diff;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS-1))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == S_DIVN)
                    begin
                        rn_next = neg_reg ? -$signed(quo_next) : $signed(quo_next);
                        quo_next   = md_reg;
                        state_next = S_DIVD;
                    end
                    else
                    begin
                        rd_next    = quo_next[62:0];
                        state_next = S_FIN;
                    end
                end
            end
            S_FIN:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    on_next    = rn_reg;
                    od_next    = rd_reg;
                    oo_next    = ro_reg;
                    os_next    = rs_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        an_reg <= an_next;  ad_reg <= ad_next;  bn_reg <= bn_next;  bd_reg <= bd_next;
        mode_reg <= mode_next;
        p0_reg <= p0_next;  p1_reg <= p1_next;  p2_reg <= p2_next;
        gx_reg <= gx_next;  gy_reg <= gy_next;  gk_reg <= gk_next;
        md_reg <= md_next;  dv_reg <= dv_next;  quo_reg <= quo_next;
        rem_reg <= rem_next;  cnt_reg <= cnt_next;  neg_reg <= neg_next;
        rn_reg <= rn_next;  rd_reg <= rd_next;  ro_reg <= ro_next;  rs_reg <= rs_next;
        on_reg <= on_next;  od_reg <= od_next;  oo_reg <= oo_next;  os_reg <= os_next;
    end

    assign out_valid = ov_reg;
    assign res_num   = on_reg;
    assign res_den   = od_reg;
    assign order     = oo_reg;
    assign status    = os_reg;

    // checks on the sequencer and result shaping
    `RAR_NEXT(a_busy_after_accept, in_fire, !in_ready)
    `RAR_IMPLY(a_err_result_zero, out_valid && status == ST_DIVZERO,
               res_num == '0 && res_den == 63'd1)
    `RAR_IMPLY(a_den_nonzero, out_valid, res_den != '0)
    `RAR_IMPLY(a_order_only_ok, out_valid && order != ORD_LESS,
               status == ST_OK && res_num == '0)
    `RAR_IMPLY(a_gcd_y_nonzero, state_reg == S_GCD, gy_reg != '0)

endmodule

// ----- dv/tb_rational_arith_reduce.sv -----
// testbench for rational_arith_reduce: fraction add, subtract, multiply,
// divide and compare with lowest-terms reduction; depends on rar_pkg
module tb_rational_arith_reduce;
    import rar_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         mode = '0;
    logic signed [31:0] a_num = '0;
    logic [30:0]        a_den = '0;
    logic signed [31:0] b_num = '0;
    logic [30:0]        b_den = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [63:0] res_num;
    logic [62:0]        res_den;
    logic [1:0]         order;
    logic               status;

    typedef struct packed {
        logic signed [63:0] num;
        logic [62:0]        den;
        logic [1:0]         ord;
        logic               st;
    } frac_res_t;

    typedef struct {
        logic [2:0]         md;
        logic signed [31:0] an;
        logic [30:0]        ad;
        logic signed [31:0] bn;
        logic [30:0]        bd;
        bit                 fixed;   // expected value typed in below
        frac_res_t          want;
    } vec_t;

    frac_res_t pending_results[$];
    int        errors = 0;
    int        cycles = 0;
    bit        calm = 1'b0;          // no idling in the closing stretch
    bit        hold_off = 1'b0;      // long receiver stall requested
    bit        hold_done = 1'b0;     // long receiver stall already served
    localparam int CYCLE_LIMIT = 3000000;

    rational_arith_reduce dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic frac_res_t reduce_frac(logic signed [63:0] n, logic signed [63:0] d);
        frac_res_t   r;
        logic [63:0] mn, md, g;
        mn = (n < 0) ? -n : n;
        md = (d < 0) ? -d : d;
        r.ord = ORD_LESS;
        r.st  = ST_OK;
        if (mn == 0)
        begin
            r.num = 0;
            r.den = 1;
            return r;
        end
        g  = gcd64(mn, md);
        mn = mn / g;
        md = md / g;
        r.num = (((n < 0) != (d < 0)) ? -mn : mn);
        r.den = md[62:0];
        return r;
    endfunction

    function automatic frac_res_t predict_frac(vec_t v);
        frac_res_t          r;
        logic signed [63:0] an, ad, bn, bd, l, q;
        an = v.an;
        bn = v.bn;
        ad = {33'd0, v.ad};
        bd = {33'd0, v.bd};
        r.num = 0;
        r.den = 1;
        r.ord = ORD_LESS;
        r.st  = ST_OK;
        if (v.md > MODE_CMP)
            return r;
        if (ad == 0 || bd == 0)
        begin
            r.st = ST_DIVZERO;
            return r;
        end
        case (v.md)
            MODE_ADD: r = reduce_frac(an * bd + bn * ad, ad * bd);
            MODE_SUB: r = reduce_frac(an * bd - bn * ad, ad * bd);
            MODE_MUL: r = reduce_frac(an * bn, ad * bd);
            MODE_DIV:
                if (bn == 0)
                    r.st = ST_DIVZERO;
                else
                    r = reduce_frac(an * bd, ad * bn);
            default:
            begin
                l = an * bd;
                q = bn * ad;
                r.ord = (l < q) ? ORD_LESS : ((l == q) ? ORD_EQUAL : ORD_GREATER);
            end
        endcase
        return r;
    endfunction

    function automatic vec_t mkv(logic [2:0] md, logic signed [31:0] an, logic [30:0] ad,
                                 logic signed [31:0] bn, logic [30:0] bd);
        vec_t v;
        v.md = md; v.an = an; v.ad = ad; v.bn = bn; v.bd = bd;
        v.fixed = 1'b0;
        v.want = '{0, 1, ORD_LESS, ST_OK};
        return v;
    endfunction

    function automatic vec_t mkf(vec_t v, logic signed [63:0] n, logic [62:0] d,
                                 logic [1:0] o, logic s);
        v.fixed = 1'b1;
        v.want = '{n, d, o, s};
        return v;
    endfunction

    // random operand: small values half of the time so reduction has real common factors
    function automatic logic [31:0] rnd_num();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return $signed($urandom_range(0, 200)) - 100;
        endcase
    endfunction

    function automatic logic [30:0] rnd_den();
        case ($urandom_range(0, 3))
            0: return 31'($urandom);
            1: return $urandom_range(0, 1) ? 31'h7fff_ffff : 31'd1;
            default: return 31'($urandom_range(1, 120));
        endcase
    endfunction

    vec_t dir_tab[$];

    task automatic send_item(vec_t v);
        frac_res_t p;
        int        gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge clk);
        end
        mode = v.md; a_num = v.an; a_den = v.ad; b_num = v.bn; b_den = v.bd;
        in_valid = 1'b1;
        p = predict_frac(v);
        if (v.fixed && p != v.want)
        begin
            $display("%0t table row disagrees with predictor: exp %p got %p", $time, v.want, p);
            errors++;
        end
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(v.fixed ? v.want : p);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        frac_res_t e;
        cycles++;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t unexpected result item num %0d den %0d", $time, res_num, res_den);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (res_num !== e.num)
                begin
                    $display("%0t res_num exp %0d got %0d", $time, e.num, res_num);
                    errors++;
                end
                if (res_den !== e.den)
                begin
                    $display("%0t res_den exp %0d got %0d", $time, e.den, res_den);
                    errors++;
                end
                if (order !== e.ord)
                begin
                    $display("%0t order exp %0d got %0d", $time, e.ord, order);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $display("%0t status exp %0d got %0d", $time, e.st, status);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold-off on request
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off && !hold_done)
            begin
                out_ready = 1'b0;
                n = 0;
                while (n < 600)
                begin
                    @(negedge clk);
                    n++;
                end
                hold_done = 1'b1;
            end
            else if (!calm && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                n = $urandom_range(1, 8);
                repeat (n - 1) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        vec_t v;
        int   k;
        // extremes, every mode, zero results, division by zero, bad denominators
        dir_tab.push_back(mkf(mkv(MODE_ADD, 0, 1, 0, 1), 0, 1, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_ADD, 1, 1, 1, 1), 2, 1, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_SUB, 5, 3, 1, 1), 2, 3, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_SUB, 1, 2, 1, 2), 0, 1, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_MUL, 2, 3, 3, 4), 1, 2, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_MUL, -2, 3, 3, 4), -1, 2, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_DIV, 1, 2, -1, 4), -2, 1, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_DIV, 7, 3, 0, 5), 0, 1, ORD_LESS, ST_DIVZERO));
        dir_tab.push_back(mkf(mkv(MODE_CMP, 1, 2, 2, 4), 0, 1, ORD_EQUAL, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_CMP, 1, 3, 1, 2), 0, 1, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_CMP, -1, 3, -1, 2), 0, 1, ORD_GREATER, ST_OK));
        dir_tab.push_back(mkf(mkv(MODE_ADD, 3, 0, 1, 1), 0, 1, ORD_LESS, ST_DIVZERO));
        dir_tab.push_back(mkf(mkv(MODE_CMP, 3, 1, 1, 0), 0, 1, ORD_LESS, ST_DIVZERO));
        dir_tab.push_back(mkf(mkv(3'd5, 9, 2, 4, 3), 0, 1, ORD_LESS, ST_OK));
        dir_tab.push_back(mkf(mkv(3'd7, -9, 2, 4, 3), 0, 1, ORD_LESS, ST_OK));
        dir_tab.push_back(mkv(MODE_ADD, 32'sh8000_0000, 31'h7fff_ffff,
                              32'sh8000_0000, 31'h7fff_fffe));
        dir_tab.push_back(mkv(MODE_SUB, 32'sh7fff_ffff, 31'h7fff_ffff,
                              32'sh8000_0000, 31'd1));
        dir_tab.push_back(mkv(MODE_MUL, 32'sh8000_0000, 31'd1, 32'sh8000_0000, 31'd1));
        dir_tab.push_back(mkv(MODE_DIV, 32'sh8000_0000, 31'd3, 32'sh7fff_ffff, 31'h7fff_ffff));
        dir_tab.push_back(mkv(MODE_CMP, 32'sh7fff_ffff, 31'h7fff_ffff,
                              32'sh8000_0000, 31'h7fff_ffff));
        dir_tab.push_back(mkv(MODE_ADD, -1, 31'h5555_5555, 32'h5555_5555, 31'h2aaa_aaaa));

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i]);

        for (k = 0; k < 2000; k++)
        begin
            if (k == 300)
                hold_off = 1'b1;   // sender keeps offering through the stall
            if (k == 1800)
                calm = 1'b1;
            v = mkv($urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
                    rnd_num(), rnd_den(), rnd_num(), rnd_den());
            if ($urandom_range(0, 40) == 0)
                v.ad = '0;
            if ($urandom_range(0, 40) == 0)
                v.bd = '0;
            if ($urandom_range(0, 15) == 0)
                v.bn = '0;
            send_item(v);
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+rtl
rtl/rar_pkg.sv
rtl/rational_arith_reduce.sv
dv/tb_rational_arith_reduce.sv
